FILE: hdl/bsps_pkg.sv
`default_nettype none
package bsps_pkg;

  // Field widths
  localparam int CAP_FIELD_BITS = 32;
  localparam int LOGE_BITS      = 6;
  localparam int SIZE_BITS      = 40;
  localparam int HASH_BITS      = 7;
  localparam int K1_BITS        = 7;
  localparam int IN_DATA_BITS   = 40;
  localparam int OUT_DATA_BITS  = 48;

  // Default number of capacity bits used
  localparam int CAP_BITS_DEF   = 32;

  // Trial divisor width: divisors stay at or below sqrt(2^40) + 2
  localparam int TRIAL_BITS     = 21;

  // Width of 9 * table_size
  localparam int SIZE9_BITS     = SIZE_BITS + 4;

  // Arithmetic constants
  localparam logic [32:0]          LOG2E_Q32    = 33'd6196328019;
  localparam logic [SIZE_BITS-1:0] MAX_PRIME_40 = 40'd1099511627689;
  localparam logic [HASH_BITS-1:0] HASH_MAX     = 7'd127;
  localparam int                   SCALE_DEN    = 9;
  localparam int                   FIRST_DIVISOR = 3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL13,
    ST_MULK,
    ST_SCALE,
    ST_SCALE_W,
    ST_TRIAL,
    ST_TRIAL_W,
    ST_HASH,
    ST_HASH_W,
    ST_DONE
  } bsps_state_t;

  // Status from the shared divider
  typedef struct packed {
    logic done;       // one-cycle pulse, quotient valid from here on
    logic rem_zero;   // remainder of the finished division is zero
  } div_stat_t;

  // First hash count: floor(t * log2(e)) with a Q1.32 constant
  function automatic logic [K1_BITS-1:0] k1_of(input logic [LOGE_BITS-1:0] t);
    logic [38:0] p;
    p = {33'd0, t} * {6'd0, LOG2E_Q32};
    return p[38:32];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bsps_div.sv
`default_nettype none
module bsps_div #(
  parameter int DIVW = 44,
  parameter int DSW  = 36
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVW-1:0]       dividend,
  input  wire logic [DSW-1:0]        divisor,
  output logic      [DIVW-1:0]       quotient,
  output bsps_pkg::div_stat_t        stat
);
  import bsps_pkg::*;

  localparam int CW = $clog2(DIVW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [DIVW-1:0] quo_r, quo_nxt;
  logic [DSW-1:0]  rem_r, rem_nxt;
  logic [DSW-1:0]  dvs_r;
  logic [DSW:0]    rem_sh;
  logic [DSW:0]    rem_sub;
  logic            qbit;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    qbit    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = qbit ? rem_sub[DSW-1:0] : rem_sh[DSW-1:0];
    quo_nxt = {quo_r[DIVW-2:0], qbit};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DIVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient      = quo_r;
  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule
`default_nettype wire

FILE: hdl/bloom_size_prime_search.sv
`default_nettype none
// Bloom filter sizing. Each input word carries a capacity n and an error term
// t = trunc(-ln e); the block returns one result word with the table size (the
// smallest odd prime at or above floor(13*n*k1/9), k1 = floor(t*log2 e),
// saturated to 2^40-87), the hash count floor(9*size/(13*n)) capped at 127,
// and a flag for zero capacity, which gives zero size and count. All division
// runs through one restoring divider of DIVW = max(CAPACITY_BITS+11, 44) bits
// that retires one quotient bit per cycle. Each candidate tried takes up to
// sqrt(candidate)/2 trial divisions. in_tready is high only between items; a
// finished result waits in the output register while the next word is taken.
module bloom_size_prime_search #(
  parameter int CAPACITY_BITS = bsps_pkg::CAP_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [31:0] capacity, [37:32] log_error, [39:38] zero
  input  wire logic [bsps_pkg::IN_DATA_BITS-1:0]   in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [39:0] table_size, [46:40] hash_count, [47] bad_capacity
  output logic      [bsps_pkg::OUT_DATA_BITS-1:0]  out_tdata
);
  import bsps_pkg::*;

  localparam int CB   = CAPACITY_BITS;
  localparam int N13W = CB + 4;
  localparam int PW   = CB + 4 + K1_BITS;
  localparam int DIVW = (PW > SIZE9_BITS) ? PW : SIZE9_BITS;
  localparam int DSW  = (N13W > TRIAL_BITS) ? N13W : TRIAL_BITS;

  bsps_state_t state_r, state_nxt;

  logic [CB-1:0]         n_in;
  logic                  in_fire;
  logic                  out_free;
  logic                  load_out;
  logic                  div_start;
  logic [DIVW-1:0]       div_dividend;
  logic [DSW-1:0]        div_divisor;
  logic [DIVW-1:0]       quo;
  div_stat_t             dstat;

  logic [CB-1:0]         n_r;
  logic [K1_BITS-1:0]    k1_r;
  logic [N13W-1:0]       n13_r;
  logic [PW-1:0]         prod_r;
  logic [SIZE_BITS-1:0]  cand_r;
  logic [TRIAL_BITS-1:0] d_r;
  logic [SIZE_BITS-1:0]  size_r;
  logic [HASH_BITS-1:0]  hash_r;
  logic                  bad_r;
  logic [SIZE9_BITS-1:0] size9;
  logic [SIZE_BITS-1:0]  seed;
  logic                  quo_over;
  logic                  quo_lt_d;

  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;

  assign n_in     = CB'(in_tdata[CAP_FIELD_BITS-1:0]);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Divider operands
  assign size9 = ({4'd0, size_r} << 3) + {4'd0, size_r};

  always_comb begin
    div_dividend = '0;
    div_divisor  = DSW'(SCALE_DEN);
    case (state_r)
      ST_SCALE: begin
        div_dividend = DIVW'(prod_r);
        div_divisor  = DSW'(SCALE_DEN);
      end
      ST_TRIAL: begin
        div_dividend = DIVW'(cand_r);
        div_divisor  = DSW'(d_r);
      end
      ST_HASH: begin
        div_dividend = DIVW'(size9);
        div_divisor  = DSW'(n13_r);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DSW'(SCALE_DEN);
      end
    endcase
  end

  bsps_div #(
    .DIVW (DIVW),
    .DSW  (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quo),
    .stat     (dstat)
  );

  // Quotient tests
  assign quo_over = (quo > DIVW'(MAX_PRIME_40));
  assign quo_lt_d = (quo < DIVW'(d_r));
  assign seed     = (quo[SIZE_BITS-1:0] < SIZE_BITS'(FIRST_DIVISOR)) ?
                    SIZE_BITS'(FIRST_DIVISOR) : (quo[SIZE_BITS-1:0] | 40'd1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = (n_in == '0) ? ST_DONE : ST_MUL13;
      end
      ST_MUL13:   state_nxt = ST_MULK;
      ST_MULK:    state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_SCALE_W;
      ST_SCALE_W: begin
        if (dstat.done) state_nxt = quo_over ? ST_HASH : ST_TRIAL;
      end
      ST_TRIAL:   state_nxt = ST_TRIAL_W;
      ST_TRIAL_W: begin
        if (dstat.done) state_nxt = quo_lt_d ? ST_HASH : ST_TRIAL;
      end
      ST_HASH:    state_nxt = ST_HASH_W;
      ST_HASH_W: begin
        if (dstat.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    div_start = (state_r inside {ST_SCALE, ST_TRIAL, ST_HASH});
    load_out  = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          n_r    <= n_in;
          k1_r   <= k1_of(in_tdata[CAP_FIELD_BITS +: LOGE_BITS]);
          bad_r  <= (n_in == '0);
          size_r <= '0;
          hash_r <= '0;
        end
      end
      ST_MUL13: begin
        n13_r <= ({4'd0, n_r} << 3) + ({4'd0, n_r} << 2) + {4'd0, n_r};
      end
      ST_MULK: begin
        prod_r <= PW'(n13_r) * PW'(k1_r);
      end
      ST_SCALE_W: begin
        if (dstat.done) begin
          if (quo_over) begin
            size_r <= MAX_PRIME_40;
          end else begin
            cand_r <= seed;
            d_r    <= TRIAL_BITS'(FIRST_DIVISOR);
          end
        end
      end
      ST_TRIAL_W: begin
        if (dstat.done) begin
          if (quo_lt_d) begin
            size_r <= cand_r;
          end else if (dstat.rem_zero) begin
            cand_r <= cand_r + 40'd2;
            d_r    <= TRIAL_BITS'(FIRST_DIVISOR);
          end else begin
            d_r <= d_r + TRIAL_BITS'(2);
          end
        end
      end
      ST_HASH_W: begin
        if (dstat.done) begin
          hash_r <= (quo > DIVW'(HASH_MAX)) ? HASH_MAX : quo[HASH_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= {bad_r, hash_r, size_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

FILE: hdl/bsps_checker.sv
`default_nettype none
module bsps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Zero capacity gives zero size and count
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[47] |-> out_tdata[46:0] == 47'd0)
    else $error("bad capacity with nonzero fields");

  // Valid capacity gives an odd size of at least three
  a_size_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[47] |-> out_tdata[0] && (out_tdata[39:1] != 39'd0))
    else $error("table size not an odd number of at least three");

  // One word in flight: busy right after taking a word
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is in flight");

endmodule

bind bloom_size_prime_search bsps_checker u_bsps_checker (.*);
`default_nettype wire
